>>> design/mfps_pkg.sv
// Shared types and constants for the maximum falling path sum block.
`default_nettype none

package mfps_pkg;

   localparam int CELL_W  = 16;
   localparam int SUM_W   = 32;
   localparam int WIDTH_W = 7;

   typedef logic [WIDTH_W-1:0]      width_reg_type;
   typedef logic signed [CELL_W-1:0] cell_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   localparam width_reg_type WIDTH_RESET = width_reg_type'(64);
   localparam sum_type       SUM_MAX     = {1'b0, {(SUM_W-1){1'b1}}};
   localparam sum_type       SUM_MIN     = {1'b1, {(SUM_W-1){1'b0}}};

   // Per-cell control that travels from the column sequencer to the sum unit.
   typedef struct packed {
      cell_type cell_value;
      logic     last_cell;
      logic     first_row;
      logic     row_end;
      logic     col_zero;
   } cell_info_type;

endpackage

`default_nettype wire

>>> design/mfps_req_if.sv
// Input channel carrying one matrix cell per word.
`default_nettype none

interface mfps_req_if;
   import mfps_pkg::*;

   logic     valid;
   logic     ready;
   cell_type cell_value;
   logic     last_cell;

   modport source (output valid, output cell_value, output last_cell, input ready);
   modport sink   (input valid, input cell_value, input last_cell, output ready);
endinterface

`default_nettype wire

>>> design/mfps_rsp_if.sv
// Result channel carrying one path sum result per word.
`default_nettype none

interface mfps_rsp_if;
   import mfps_pkg::*;

   logic    valid;
   logic    ready;
   sum_type max_path_sum;
   logic    saturated;

   modport source (output valid, output max_path_sum, output saturated, input ready);
   modport sink   (input valid, input max_path_sum, input saturated, output ready);
endinterface

`default_nettype wire

>>> design/max_falling_path_sum.sv
// Top level of the streaming maximum falling path sum block.
//
// Cells of a matrix arrive in row-major order on req_chan, one signed 16-bit
// value per word, with last_cell set on the final cell of the matrix. The row
// width comes from csr_wr_data, written while the block is idle; zero counts as
// one column and values above MAX_COLS count as MAX_COLS.
// Each cell adds the largest of the up to three path sums above it (left, center,
// right, within the row); first-row cells take their own value. Sums saturate at
// the signed 32-bit limits. After the last cell one word appears on rsp_chan with
// the maximum over the final row and a flag set if any sum of that matrix clamped.
// Throughput is one cell per cycle while no last cell waits on a full result
// register. Each cell but a row's last reads its right neighbor from the line
// buffer when accepted and writes its own sum when it leaves the cell stage; the
// value above is the previous cell's right read, and column zero has its own copy.
// A result is valid once its last cell has passed into the result register.
// When rsp_chan stalls, input cells keep flowing until another last cell reaches
// the sum stage, which then waits for the result register to empty.
// Reset clears the column, row and result state; the line buffer is not cleared,
// since every entry is written by the first row before any later row reads it.
`default_nettype none

module max_falling_path_sum #(
   parameter int MAX_COLS = 64
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_wr_en,
   input  wire mfps_pkg::width_reg_type csr_wr_data,
   mfps_req_if.sink                     req_chan,
   mfps_rsp_if.source                   rsp_chan
);
   import mfps_pkg::*;

   localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   width_reg_type    row_width_ff;
   logic             accept;
   logic             rd_en;
   logic [COL_W-1:0] rd_addr;
   sum_type          rd_data;
   logic             s1_valid;
   cell_info_type    s1_info;
   logic [COL_W-1:0] s1_col;
   logic             fwd_hit;
   sum_type          fwd_data;
   logic             s1_adv;
   logic             wr_en;
   sum_type          wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= WIDTH_RESET;
      end else if (csr_wr_en) begin
         row_width_ff <= csr_wr_data;
      end
   end

   // A new cell enters whenever the cell stage is empty or moving on.
   assign req_chan.ready = !s1_valid || s1_adv;
   assign accept         = req_chan.valid && req_chan.ready;

   mfps_col_seq #(
      .MAX_COLS (MAX_COLS),
      .COL_W    (COL_W)
   ) u_col_seq (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .cell_value (req_chan.cell_value),
      .last_cell  (req_chan.last_cell),
      .row_width  (row_width_ff),
      .s1_adv     (s1_adv),
      .wr_en      (wr_en),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .s1_valid   (s1_valid),
      .s1_info    (s1_info),
      .s1_col     (s1_col),
      .fwd_hit    (fwd_hit),
      .fwd_data   (fwd_data)
   );

   // Line buffer holding the previous row's best sums, one entry per column.
   mfps_ram #(
      .WIDTH (SUM_W),
      .DEPTH (MAX_COLS)
   ) u_row_sums (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_col),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mfps_sum_unit u_sum_unit (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid),
      .s1_info  (s1_info),
      .rd_data  (rd_data),
      .fwd_hit  (fwd_hit),
      .fwd_data (fwd_data),
      .s1_adv   (s1_adv),
      .wr_en    (wr_en),
      .wr_data  (wr_data),
      .rsp      (rsp_chan)
   );

endmodule

`default_nettype wire

>>> design/mfps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module mfps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // A read of the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> design/mfps_col_seq.sv
// Column sequencer: tracks the column and row, issues line-buffer reads, holds the cell stage.
`default_nettype none

module mfps_col_seq #(
   parameter int MAX_COLS = 64,
   parameter int COL_W    = 6
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire mfps_pkg::cell_type      cell_value,
   input  wire logic                    last_cell,
   input  wire mfps_pkg::width_reg_type row_width,
   input  wire logic                    s1_adv,
   input  wire logic                    wr_en,
   input  wire mfps_pkg::sum_type       wr_data,
   output logic                         rd_en,
   output logic [COL_W-1:0]             rd_addr,
   output logic                         s1_valid,
   output mfps_pkg::cell_info_type      s1_info,
   output logic [COL_W-1:0]             s1_col,
   output logic                         fwd_hit,
   output mfps_pkg::sum_type            fwd_data
);
   import mfps_pkg::*;

   localparam int CNT_W = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_COLS);

   logic [COL_W-1:0] column_ff, column_in;
   logic             first_row_ff, first_row_in;
   logic             s1_valid_ff, s1_valid_in;
   logic [CNT_W-1:0] width_eff;
   logic [CNT_W-1:0] next_col;
   logic             row_end;

   always_comb begin
      width_eff = CNT_W'(row_width);
      if (width_eff == '0) begin
         width_eff = CNT_W'(1);
      end else if (width_eff > MAX_CNT) begin
         width_eff = MAX_CNT;
      end
      next_col = CNT_W'(column_ff) + CNT_W'(1);
      row_end  = (next_col >= width_eff);
   end

   // The right neighbour is fetched now; it becomes the next cell's value above.
   assign rd_en   = accept && !row_end;
   assign rd_addr = next_col[COL_W-1:0];

   always_comb begin
      column_in    = column_ff;
      first_row_in = first_row_ff;
      s1_valid_in  = s1_valid_ff;
      if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
         if (last_cell) begin
            column_in    = '0;
            first_row_in = 1'b1;
         end else if (row_end) begin
            column_in    = '0;
            first_row_in = 1'b0;
         end else begin
            column_in    = next_col[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         first_row_ff <= 1'b1;
         s1_valid_ff  <= 1'b0;
      end else begin
         column_ff    <= column_in;
         first_row_ff <= first_row_in;
         s1_valid_ff  <= s1_valid_in;
      end
   end

   // Payload of the cell stage, plus capture of a write that lands on the address
   // being read in the same cycle.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info.cell_value <= cell_value;
         s1_info.last_cell  <= last_cell;
         s1_info.first_row  <= first_row_ff;
         s1_info.row_end    <= row_end;
         s1_info.col_zero   <= (column_ff == '0);
         s1_col             <= column_ff;
      end
      if (rd_en) begin
         fwd_hit  <= wr_en && (s1_col == rd_addr);
         fwd_data <= wr_data;
      end
   end

   assign s1_valid = s1_valid_ff;

endmodule

`default_nettype wire

>>> design/mfps_sum_unit.sv
// Sum unit: neighbour maximum, saturating add, running row maximum and result register.
`default_nettype none

module mfps_sum_unit (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    s1_valid,
   input  wire mfps_pkg::cell_info_type s1_info,
   input  wire mfps_pkg::sum_type       rd_data,
   input  wire logic                    fwd_hit,
   input  wire mfps_pkg::sum_type       fwd_data,
   output logic                         s1_adv,
   output logic                         wr_en,
   output mfps_pkg::sum_type            wr_data,
   mfps_rsp_if.source                   rsp
);
   import mfps_pkg::*;

   sum_type left_ff, above_hold_ff, col0_ff;
   sum_type row_max_ff, row_max_in;
   logic    ovf_ff, ovf_in;
   logic    rsp_valid_ff, rsp_valid_in;

   sum_type               above, right, best, sum, new_max;
   logic signed [SUM_W:0] total;
   logic                  clamp_hit, new_ovf;

   always_comb begin
      above = s1_info.col_zero ? col0_ff : above_hold_ff;
      right = fwd_hit ? fwd_data : rd_data;
      best  = above;
      if (!s1_info.col_zero && (left_ff > best)) begin
         best = left_ff;
      end
      if (!s1_info.row_end && (right > best)) begin
         best = right;
      end
      total = {{(SUM_W + 1 - CELL_W){s1_info.cell_value[CELL_W-1]}}, s1_info.cell_value}
            + {best[SUM_W-1], best};
      clamp_hit = 1'b0;
      if (s1_info.first_row) begin
         sum = SUM_W'(s1_info.cell_value);
      end else if (total[SUM_W] != total[SUM_W-1]) begin
         clamp_hit = 1'b1;
         sum = total[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         sum = total[SUM_W-1:0];
      end
      new_max = (s1_info.col_zero || (sum > row_max_ff)) ? sum : row_max_ff;
      new_ovf = ovf_ff || clamp_hit;
   end

   // Only a final cell can be held back, and only while the result register is full.
   assign s1_adv  = s1_valid && !(s1_info.last_cell && rsp_valid_ff && !rsp.ready);
   assign wr_en   = s1_adv;
   assign wr_data = sum;

   always_comb begin
      row_max_in   = row_max_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (s1_adv) begin
         if (s1_info.last_cell) begin
            row_max_in   = SUM_MIN;
            ovf_in       = 1'b0;
            rsp_valid_in = 1'b1;
         end else begin
            row_max_in = new_max;
            ovf_in     = new_ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_max_ff   <= SUM_MIN;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_max_ff   <= row_max_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         left_ff       <= above;
         above_hold_ff <= right;
         if (s1_info.col_zero) begin
            col0_ff <= sum;
         end
         if (s1_info.last_cell) begin
            rsp.max_path_sum <= new_max;
            rsp.saturated    <= new_ovf;
         end
      end
   end

   assign rsp.valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> design/mfps_checker.sv
// Port-level checker for the maximum falling path sum block, bound to the top level.
`default_nettype none

module mfps_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                req_last,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire mfps_pkg::sum_type   rsp_sum,
   input wire logic                rsp_sat
);

   // The block leaves reset with no result pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A new result only follows the acceptance of a final cell.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last, 2))
      else $error("result without a final cell");

   // The input is only held back by a stalled result.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input stalled while output free");

   // A pending result holds its word until taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_sum) && $stable(rsp_sat)))
      else $error("result changed while stalled");

endmodule

bind max_falling_path_sum mfps_checker u_mfps_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_last  (req_chan.last_cell),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_sum   (rsp_chan.max_path_sum),
   .rsp_sat   (rsp_chan.saturated)
);

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for the maximum falling path sum block.
module tb_top;
   import mfps_pkg::*;

   localparam int MAX_COLS       = 64;
   // Idle cycles waited after the expected words have arrived, so that every
   // cell still in flight has retired.
   localparam int DRAIN_CYCLES   = 4;
   localparam int RANDOM_CELLS   = 600;
   localparam int RANDOM_MATRIX  = 20;
   localparam int LONG_HOLD      = 400;
   localparam int MAX_REPORTS    = 10;
   // The limit is well above the time taken by about 650 cells with the sender's
   // gaps, the receiver's stall patterns and width writes, and the two long
   // hold-offs.
   localparam int CYCLE_LIMIT    = 100_000;

   // One result word as the block reports it.
   typedef struct packed {
      sum_type path_sum;
      logic    saturated;
   } result_type;

   // A directed row either writes the row width or streams a run of equal cells.
   typedef enum logic {ROW_WIDTH, ROW_CELLS} row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      width_reg_type width;
      cell_type      value;
      int            count;
      logic          last;
      logic          typed;
      result_type    want;
   } dir_row_type;

   localparam result_type NO_RESULT = '0;
   localparam int NUM_DIR_ROWS = 27;

   // Rows with typed set carry an expected word that can be read off by hand;
   // all other results come from the predictor.
   localparam dir_row_type DIRECTED [NUM_DIR_ROWS] = '{
      // Straight out of reset the width is 64. A lone cell marked last is its
      // own maximum, which also ends the matrix in the middle of the first row.
      '{ROW_CELLS, 7'd0,   16'sh7FFF,     1,     1'b1, 1'b1, '{32'sd32767, 1'b0}},
      // One column: every row adds the cell to the single sum above it.
      '{ROW_WIDTH, 7'd1,   16'sh0000,     0,     1'b0, 1'b0, NO_RESULT},
      '{ROW_CELLS, 7'd0,   16'sh8000,     3,     1'b1, 1'b1, '{-32'sd98304, 1'b0}},
      // A width of zero behaves as one column.
      '{ROW_WIDTH, 7'd0,   16'sh0000,     0,     1'b0, 1'b0, NO_RESULT},
      '{ROW_CELLS, 7'd0,   16'sd5,        1,     1'b0, 1'b0, NO_RESULT},
      '{ROW_CELLS, 7'd0,   16'sd7,        1,     1'b1, 1'b1, '{32'sd12, 1'b0}},
      // Three columns, two rows: the edge columns see only two sums above.
      '{ROW_WIDTH, 7'd3,   16'sh0000,     0,     1'b0, 1'b0, NO_RESULT},
      '{ROW_CELLS, 7'd0,   16'sd1,        1,     1'b0, 1'b0, NO_RESULT},
      '{ROW_CELLS, 7'd0,   16'sd2,        1,     1'b0, 1'b0, NO_RESULT},
      '{ROW_CELLS, 7'd0,   16'sd3,        1,     1'b0, 1'b0, NO_RESULT},
      '{ROW_CELLS, 7'd0,   16'sd4,        1,     1'b0, 1'b0, NO_RESULT},
      '{ROW_CELLS, 7'd0,   16'sd5,        1,     1'b0, 1'b0, NO_RESULT},
      '{ROW_CELLS, 7'd0,   16'sd6,        1,     1'b1, 1'b1, '{32'sd9, 1'b0}},
      // Last mark in the middle of a row: maximum over the cells seen so far.
      '{ROW_CELLS, 7'd0,   16'sd10,       1,     1'b0, 1'b0, NO_RESULT},
      '{ROW_CELLS, 7'd0,  -16'sd4,        1,     1'b1, 1'b1, '{32'sd10, 1'b0}},
      // The largest register value is capped at the line buffer size.
      '{ROW_WIDTH, 7'd127, 16'sh0000,     0,     1'b0, 1'b0, NO_RESULT},
      '{ROW_CELLS, 7'd0,   16'sd3,        1,     1'b1, 1'b1, '{32'sd3, 1'b0}},
      // Four columns, then the width shrinks to two while the second row is at
      // column two. That cell ends its row and has no right neighbor.
      '{ROW_WIDTH, 7'd4,   16'sh0000,     0,     1'b0, 1'b0, NO_RESULT},
      '{ROW_CELLS, 7'd0,  -16'sd1,        1,     1'b0, 1'b0, NO_RESULT},
      '{ROW_CELLS, 7'd0,  -16'sd2,        1,     1'b0, 1'b0, NO_RESULT},
      '{ROW_CELLS, 7'd0,  -16'sd3,        1,     1'b0, 1'b0, NO_RESULT},
      '{ROW_CELLS, 7'd0,  -16'sd4,        1,     1'b0, 1'b0, NO_RESULT},
      '{ROW_CELLS, 7'd0,   16'sd100,      1,     1'b0, 1'b0, NO_RESULT},
      '{ROW_CELLS, 7'd0,   16'sd200,      1,     1'b0, 1'b0, NO_RESULT},
      '{ROW_WIDTH, 7'd2,   16'sh0000,     0,     1'b0, 1'b0, NO_RESULT},
      '{ROW_CELLS, 7'd0,   16'sd300,      1,     1'b0, 1'b0, NO_RESULT},
      '{ROW_CELLS, 7'd0,  -16'sd5,        1,     1'b1, 1'b0, NO_RESULT}
   };

   logic          clock;
   logic          reset;
   logic          csr_wr_en;
   width_reg_type csr_wr_data;

   mfps_req_if req_chan ();
   mfps_rsp_if rsp_chan ();

   max_falling_path_sum #(
      .MAX_COLS    (MAX_COLS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor state: the width register, the line buffer of best sums from
   // the row above, and the position within the current matrix.
   // ------------------------------------------------------------------------
   width_reg_type       pred_width     = WIDTH_RESET;
   sum_type             line_sums [MAX_COLS] = '{default: '0};
   // Tracks which line buffer entries were written since reset, so that the
   // stimulus never grows the width mid-matrix onto entries holding no value.
   logic [MAX_COLS-1:0] ever_written   = '0;
   sum_type             pred_left      = '0;
   int                  pred_col       = 0;
   bit                  pred_first_row = 1'b1;
   sum_type             pred_row_max   = SUM_MIN;
   bit                  pred_clamped   = 1'b0;

   // Expected result words, oldest first.
   result_type pending_maxima [$];

   int errors       = 0;
   int results_seen = 0;
   int burst_left   = 0;
   int hold_left    = 0;

   // The register value as the block uses it: zero means one column and
   // anything beyond the buffer means the full buffer.
   function automatic int eff_width(input width_reg_type w);
      if (w == 0) return 1;
      if (w > MAX_COLS) return MAX_COLS;
      return int'(w);
   endfunction

   // Advances the path sums by one cell. Returns 1 and fills res when the cell
   // closes a matrix.
   function automatic bit advance_path_sums(input cell_type v, input logic l,
                                            output result_type res);
      int      w;
      int      j;
      bit      row_end;
      sum_type above;
      sum_type s;
      longint  best;
      longint  total;

      res     = NO_RESULT;
      w       = eff_width(pred_width);
      j       = pred_col;
      // A column at or past the width also ends the row, which covers a width
      // that shrank while the row was under way.
      row_end = (j + 1 >= w);
      above   = line_sums[j];

      if (pred_first_row) begin
         s = sum_type'(v);
      end else begin
         best = longint'(above);
         if (j > 0 && pred_left > best) best = longint'(pred_left);
         if (!row_end && line_sums[j+1] > best) best = longint'(line_sums[j+1]);
         total = longint'(v) + best;
         if (total > longint'(SUM_MAX)) begin
            s = SUM_MAX;
            pred_clamped = 1'b1;
         end else if (total < longint'(SUM_MIN)) begin
            s = SUM_MIN;
            pred_clamped = 1'b1;
         end else begin
            s = sum_type'(total);
         end
      end

      // The center sum read now is the left neighbor of the next column.
      pred_left       = above;
      line_sums[j]    = s;
      ever_written[j] = 1'b1;
      if (j == 0 || s > pred_row_max) pred_row_max = s;

      if (l) begin
         res.path_sum   = pred_row_max;
         res.saturated  = pred_clamped;
         pred_left      = '0;
         pred_col       = 0;
         pred_first_row = 1'b1;
         pred_row_max   = SUM_MIN;
         pred_clamped   = 1'b0;
         return 1'b1;
      end

      if (row_end) begin
         pred_col       = 0;
         pred_first_row = 1'b0;
         pred_left      = '0;
      end else begin
         pred_col = j + 1;
      end
      return 1'b0;
   endfunction

   // Mostly narrow rows; full-buffer and out-of-range values come up rarely so
   // that the cell budget is not spent on a few wide matrices.
   function automatic width_reg_type pick_width();
      int r;

      r = $urandom_range(0, 31);
      if (r == 0) return width_reg_type'(0);
      if (r == 1) return width_reg_type'(64);
      if (r == 2) return width_reg_type'($urandom_range(65, 127));
      if (r == 3) return width_reg_type'(127);
      if (r < 8) return width_reg_type'($urandom_range(9, 63));
      return width_reg_type'($urandom_range(1, 8));
   endfunction

   // Offers one word on the input channel and returns at the edge that
   // accepts it. The sender runs in bursts; between bursts valid drops low for
   // a random gap. Ready is looked at on the falling edge, where it is settled.
   task automatic send_word(input cell_type v, input logic l);
      if (burst_left == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
      end
      burst_left--;
      req_chan.valid      <= 1'b1;
      req_chan.cell_value <= v;
      req_chan.last_cell  <= l;
      @(negedge clock);
      while (!req_chan.ready) @(negedge clock);
      @(posedge clock);
   endtask

   // Runs the predictor on one cell, queues the expected word if the cell
   // closes a matrix, and sends the cell. A typed expectation replaces the
   // predicted one while the predictor still advances.
   task automatic drive_cell(input cell_type v, input logic l, input bit typed,
                             input result_type typed_res);
      result_type res;

      if (advance_path_sums(v, l, res))
         pending_maxima.push_back(typed ? typed_res : res);
      send_word(v, l);
   endtask

   // The width is written only with the block idle: all expected words have
   // arrived and any cells that produce no word have had time to retire.
   task automatic set_width(input width_reg_type w);
      req_chan.valid <= 1'b0;
      while (pending_maxima.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= w;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      pred_width  = w;
   endtask

   task automatic log_error(input string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%s", msg);
   endtask

   // ------------------------------------------------------------------------
   // Result checker. The handshake completes at the next rising edge; nothing
   // on the channel changes between this falling edge and that one.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      result_type want;

      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (pending_maxima.size() == 0) begin
            log_error($sformatf("unexpected result word: sum %0d saturated %0b",
                                rsp_chan.max_path_sum, rsp_chan.saturated));
         end else begin
            want = pending_maxima.pop_front();
            if (rsp_chan.max_path_sum !== want.path_sum ||
                rsp_chan.saturated !== want.saturated)
               log_error($sformatf({"result word %0d: expected sum %0d saturated %0b, ",
                                    "got sum %0d saturated %0b"},
                                   results_seen, want.path_sum, want.saturated,
                                   rsp_chan.max_path_sum, rsp_chan.saturated));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver. It switches between always ready, coin-flip ready and a short
   // repeating stall pattern. Twice it holds off for a long stretch while the
   // sender keeps going, so that a second last cell reaches the sum stage
   // behind an unread result and the block has to stall its input.
   // ------------------------------------------------------------------------
   initial begin
      int         mode;
      int         mode_left;
      int         holds_done;
      logic [7:0] pattern;

      mode       = 0;
      mode_left  = 0;
      holds_done = 0;
      pattern    = '1;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (holds_done < 2 && results_seen >= 15 + 10 * holds_done) begin
            hold_left = LONG_HOLD;
            holds_done++;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 2);
               mode_left = $urandom_range(20, 80);
               pattern   = 8'($urandom_range(0, 255));
            end
            mode_left--;
            case (mode)
               0:       rsp_chan.ready <= 1'b1;
               1:       rsp_chan.ready <= 1'($urandom_range(0, 1));
               default: rsp_chan.ready <= pattern[mode_left % 8];
            endcase
         end
      end
   end

   // Watchdog.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb_top: done, errors");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus: the directed table first, then random matrices.
   // ------------------------------------------------------------------------
   initial begin
      int            ncols;
      int            rows;
      int            total;
      int            change_at;
      int            random_cells;
      int            matrices;
      bit            safe;
      cell_type      v;
      width_reg_type nw;

      random_cells = 0;
      matrices     = 0;

      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= '0;
      req_chan.valid      <= 1'b0;
      req_chan.cell_value <= '0;
      req_chan.last_cell  <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIR_ROWS; i++) begin
         if (DIRECTED[i].kind == ROW_WIDTH) begin
            set_width(DIRECTED[i].width);
         end else begin
            for (int k = 0; k < DIRECTED[i].count; k++)
               drive_cell(DIRECTED[i].value,
                          DIRECTED[i].last && (k == DIRECTED[i].count - 1),
                          DIRECTED[i].typed, DIRECTED[i].want);
         end
      end

      // Random matrices of a few rows with random content. Width changes come
      // between matrices and sometimes in the middle of one; they are held
      // back during a long receiver hold-off so that the sender keeps pushing.
      while (random_cells < RANDOM_CELLS || matrices < RANDOM_MATRIX) begin
         if (hold_left == 0 && $urandom_range(0, 1) == 0) set_width(pick_width());
         ncols = eff_width(pred_width);
         rows  = (ncols > 16) ? $urandom_range(1, 2) : $urandom_range(1, 6);
         total = rows * ncols;
         // Now and then the last mark falls in the middle of the final row.
         if ($urandom_range(0, 4) == 0)
            total = (rows - 1) * ncols + $urandom_range(1, ncols);
         change_at = (total > 1 && $urandom_range(0, 7) == 0) ?
                     $urandom_range(1, total - 1) : -1;

         for (int k = 0; k < total; k++) begin
            if (k == change_at && hold_left == 0) begin
               nw = pick_width();
               // After the first row, growing the width may only reach line
               // buffer entries that already hold a sum.
               safe = pred_first_row ||
                      (&(ever_written | ~((64'd1 << eff_width(nw)) - 64'd1)));
               if (safe) set_width(nw);
            end
            case ($urandom_range(0, 7))
               0:       v = 16'sh7FFF;
               1:       v = 16'sh8000;
               2, 3:    v = cell_type'(int'($urandom_range(0, 200)) - 100);
               default: v = cell_type'($urandom_range(0, 65535));
            endcase
            drive_cell(v, k == total - 1, 1'b0, NO_RESULT);
         end
         random_cells += total;
         matrices++;
      end

      req_chan.valid <= 1'b0;
      while (pending_maxima.size() != 0) @(posedge clock);
      repeat (4 * DRAIN_CYCLES) @(posedge clock);

      if (errors == 0 && pending_maxima.size() == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

>>> files.f
design/mfps_pkg.sv
design/mfps_req_if.sv
design/mfps_rsp_if.sv
design/mfps_ram.sv
design/mfps_col_seq.sv
design/mfps_sum_unit.sv
design/max_falling_path_sum.sv
design/mfps_checker.sv
dv/tb_top.sv
